### rtl/calendar_date_advance_macros.svh
// Assertion macros for the calendar date advance block.
// Included by the modules that check their own sequencing; needs clk_i and rst_ni in scope.
`ifndef CALENDAR_DATE_ADVANCE_MACROS_SVH
`define CALENDAR_DATE_ADVANCE_MACROS_SVH

// Checked on every rising edge outside reset.
`define CDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CDA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/cda_pkg.sv
// Shared types, opcodes and calendar functions for calendar_date_advance.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package cda_pkg;

  localparam logic [2:0] OP_ADD_DAYS    = 3'd0;
  localparam logic [2:0] OP_ADD_WEEKS   = 3'd1;
  localparam logic [2:0] OP_ADD_MONTHS  = 3'd2;
  localparam logic [2:0] OP_ADD_YEARS   = 3'd3;
  localparam logic [2:0] OP_ADD_DECADES = 3'd4;

  // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for any 16-bit y
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int unsigned DIV100_SHIFT = 23;

  localparam logic [6:0]  LAST_YEAR_IN_CENTURY = 7'd99;
  localparam logic [3:0]  LAST_MONTH           = 4'd12;
  localparam logic [15:0] MAX_YEAR             = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_CHECK,
    ST_DAYS,
    ST_MONTHS,
    ST_DONE
  } cda_state_e;

  // y mod 100 and (y / 100) mod 4 give the century rules.
  function automatic logic cda_is_leap(input logic [1:0] y_lo, input logic [6:0] yr_in_cent,
                                       input logic [1:0] cent_mod4);
    logic by4;
    logic cent;
    by4  = (y_lo == 2'd0);
    cent = (yr_in_cent == 7'd0);
    return (by4 && !cent) || (cent && (cent_mod4 == 2'd0));
  endfunction

  function automatic logic [4:0] cda_month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
        len = 5'd31;
      end
      default: begin
        len = 5'd0;
      end
    endcase
    return len;
  endfunction

endpackage

### rtl/calendar_date_advance.sv
// Gregorian date advance: adds days, weeks, months, years or decades to a date.
// Depends on cda_pkg and calendar_date_advance_macros.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   command  | start, busy        | opcode_i, count_i, start_day/month/year_i
//   result   | done_o (1 cycle)   | end_day/month/year_o, year_overflow_o, invalid_date_o
//
// A transfer runs its setup states (year/100 by reciprocal multiply, remainder,
// validity check), then the shared month stepper: days and weeks take one step per
// month boundary crossed plus one, months one step per month, years, decades, zero
// counts, unused opcodes and invalid dates none; then done_o is raised.
// busy is high after acceptance up to the done_o cycle inclusive. Reset clears the
// sequencer only. The receiver cannot stall; a result is shown exactly once.
`timescale 1ns / 1ps

`include "calendar_date_advance_macros.svh"

module calendar_date_advance
  import cda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [14:0] count_i,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [15:0] start_year_i,
  output logic        done_o,
  output logic [4:0]  end_day_o,
  output logic [3:0]  end_month_o,
  output logic [15:0] end_year_o,
  output logic        year_overflow_o,
  output logic        invalid_date_o
);

  cda_state_e  state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [17:0] n_q, n_d;
  logic [4:0]  d_q, d_d;
  logic [3:0]  m_q, m_d;
  logic [15:0] y_q, y_d;
  logic [9:0]  cent_q, cent_d;
  logic [6:0]  yic_q, yic_d;
  logic [1:0]  c4_q, c4_d;
  logic        ovf_q, ovf_d;
  logic        bad_q, bad_d;

  logic        accept;
  logic [32:0] prod;
  logic [16:0] cent100;
  logic [16:0] rem;
  logic        leap_cur;
  logic [4:0]  len_cur;
  logic [4:0]  room;
  logic        fits;
  logic        bad_chk;
  logic [3:0]  m_nx;
  logic [15:0] y_nx;
  logic [6:0]  yic_nx;
  logic [1:0]  c4_nx;
  logic        wrap_nx;
  logic [4:0]  len_nx;
  logic [18:0] addend;
  logic [18:0] ysum;

  assign accept = start && !busy;

  // year / 100 and year mod 100
  assign prod    = {1'b0, y_q} * {16'd0, DIV100_MUL};
  assign cent100 = {1'b0, cent_q, 6'd0} + {2'b0, cent_q, 5'd0} + {5'b0, cent_q, 2'd0};
  assign rem     = {1'b0, y_q} - cent100;

  assign leap_cur = cda_is_leap(y_q[1:0], yic_q, c4_q);
  assign len_cur  = cda_month_len(m_q, leap_cur);
  assign room     = len_cur - d_q;
  assign fits     = (n_q <= {13'd0, room});
  assign bad_chk  = (d_q == 5'd0) || (d_q > len_cur);

  // shared month stepper
  always_comb begin
    m_nx    = m_q + 4'd1;
    y_nx    = y_q;
    yic_nx  = yic_q;
    c4_nx   = c4_q;
    wrap_nx = 1'b0;
    if (m_q == LAST_MONTH) begin
      m_nx = 4'd1;
      if (y_q == MAX_YEAR) begin
        y_nx    = 16'd0;
        yic_nx  = 7'd0;
        c4_nx   = 2'd0;
        wrap_nx = 1'b1;
      end else begin
        y_nx = y_q + 16'd1;
        if (yic_q == LAST_YEAR_IN_CENTURY) begin
          yic_nx = 7'd0;
          c4_nx  = c4_q + 2'd1;
        end else begin
          yic_nx = yic_q + 7'd1;
        end
      end
    end
  end

  assign len_nx = cda_month_len(m_nx, cda_is_leap(y_nx[1:0], yic_nx, c4_nx));

  assign addend = (op_q == OP_ADD_YEARS) ? {4'd0, n_q[14:0]}
                : ({1'b0, n_q[14:0], 3'd0} + {3'd0, n_q[14:0], 1'b0});
  assign ysum   = {3'd0, y_q} + addend;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_DIV;
      end
      ST_DIV: begin
        state_d = ST_REM;
      end
      ST_REM: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (bad_chk || n_q == 18'd0) begin
          state_d = ST_DONE;
        end else if (op_q == OP_ADD_DAYS || op_q == OP_ADD_WEEKS) begin
          state_d = ST_DAYS;
        end else if (op_q == OP_ADD_MONTHS) begin
          state_d = ST_MONTHS;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DAYS: begin
        if (fits) state_d = ST_DONE;
      end
      ST_MONTHS: begin
        if (n_q == 18'd1) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    op_d   = op_q;
    n_d    = n_q;
    d_d    = d_q;
    m_d    = m_q;
    y_d    = y_q;
    cent_d = cent_q;
    yic_d  = yic_q;
    c4_d   = c4_q;
    ovf_d  = ovf_q;
    bad_d  = bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d  = opcode_i;
          n_d   = (opcode_i == OP_ADD_WEEKS) ? ({count_i, 3'd0} - {3'd0, count_i})
                                            : {3'd0, count_i};
          d_d   = start_day_i;
          m_d   = start_month_i;
          y_d   = start_year_i;
          ovf_d = 1'b0;
          bad_d = 1'b0;
        end
      end
      ST_DIV: begin
        cent_d = prod[DIV100_SHIFT +: 10];
      end
      ST_REM: begin
        yic_d = rem[6:0];
        c4_d  = cent_q[1:0];
      end
      ST_CHECK: begin
        bad_d = bad_chk;
        if (!bad_chk && (op_q == OP_ADD_YEARS || op_q == OP_ADD_DECADES)) begin
          y_d   = ysum[15:0];
          ovf_d = |ysum[18:16];
        end
      end
      ST_DAYS: begin
        if (fits) begin
          d_d = d_q + n_q[4:0];
        end else begin
          n_d   = n_q - ({13'd0, room} + 18'd1);
          d_d   = 5'd1;
          m_d   = m_nx;
          y_d   = y_nx;
          yic_d = yic_nx;
          c4_d  = c4_nx;
          ovf_d = ovf_q | wrap_nx;
        end
      end
      ST_MONTHS: begin
        n_d   = n_q - 18'd1;
        d_d   = (d_q > len_nx) ? len_nx : d_q;
        m_d   = m_nx;
        y_d   = y_nx;
        yic_d = yic_nx;
        c4_d  = c4_nx;
        ovf_d = ovf_q | wrap_nx;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
  end

  assign end_day_o       = d_q;
  assign end_month_o     = m_q;
  assign end_year_o      = y_q;
  assign year_overflow_o = ovf_q;
  assign invalid_date_o  = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    n_q    <= n_d;
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    cent_q <= cent_d;
    yic_q  <= yic_d;
    c4_q   <= c4_d;
    ovf_q  <= ovf_d;
    bad_q  <= bad_d;
  end

  `CDA_ASSERT(a_accept_busy, accept |=> busy && !done_o, "accepted command did not raise busy")
  `CDA_ASSERT(a_done_idle, done_o |=> !busy, "block did not return to idle after result")
  `CDA_ASSERT(a_invalid_no_ovf, done_o && invalid_date_o |-> !year_overflow_o,
              "invalid date reported with overflow")
  `CDA_ASSERT(a_valid_result, done_o && !invalid_date_o |->
              end_day_o != 5'd0 && end_month_o != 4'd0 && end_month_o <= LAST_MONTH,
              "valid transfer produced an impossible date")
  `CDA_ASSERT_ALWAYS(a_done_in_busy, done_o |-> busy, "result strobe outside busy window")

endmodule

### bench/calendar_date_advance_tb.sv
// Self-checking bench for calendar_date_advance: directed calendar corner cases, then random
// requests, each result checked field by field against an in-bench date predictor.
// Depends on cda_pkg (opcodes) and the calendar_date_advance RTL.
`timescale 1ns / 1ps

module calendar_date_advance_tb;
  import cda_pkg::*;

  typedef struct {
    logic [2:0]  opcode;
    logic [14:0] count;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_req_t;

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        ovf;
    logic        bad;
  } date_res_t;

  class date_scoreboard;
    date_res_t   pending_dates[$];
    int unsigned errors = 0;

    static function int unsigned days_in(int unsigned m, int unsigned y);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
        2: return leap ? 29 : 28;
        4, 6, 9, 11: return 30;
        1, 3, 5, 7, 8, 10, 12: return 31;
        default: return 0;
      endcase
    endfunction

    function void next_month(inout int unsigned m, inout int unsigned y, inout bit ovf);
      if (m == 12) begin
        m = 1;
        if (y == 65535) begin
          y = 0;
          ovf = 1'b1;
        end else begin
          y = y + 1;
        end
      end else begin
        m = m + 1;
      end
    endfunction

    function date_res_t advance_date(date_req_t r);
      date_res_t   res;
      int unsigned d, m, y, n, room, len, sum, i;
      bit          ovf;
      bit          bad;
      d   = r.day;
      m   = r.month;
      y   = r.year;
      ovf = 1'b0;
      bad = (d == 0) || (d > days_in(m, y));
      if (!bad) begin
        case (r.opcode)
          OP_ADD_DAYS, OP_ADD_WEEKS: begin
            n = (r.opcode == OP_ADD_WEEKS) ? int'(r.count) * 7 : int'(r.count);
            while (n > 0) begin
              room = days_in(m, y) - d;
              if (n <= room) begin
                d = d + n;
                n = 0;
              end else begin
                n = n - (room + 1);
                d = 1;
                next_month(m, y, ovf);
              end
            end
          end
          OP_ADD_MONTHS: begin
            for (i = 0; i < r.count; i++) begin
              next_month(m, y, ovf);
              len = days_in(m, y);
              if (d > len) d = len;
            end
          end
          OP_ADD_YEARS, OP_ADD_DECADES: begin
            sum = y + ((r.opcode == OP_ADD_DECADES) ? int'(r.count) * 10 : int'(r.count));
            if (sum > 65535) ovf = 1'b1;
            y = sum & 16'hFFFF;
          end
          default: begin
          end
        endcase
      end
      res.day   = 5'(d);
      res.month = 4'(m);
      res.year  = 16'(y);
      res.ovf   = ovf;
      res.bad   = bad;
      return res;
    endfunction

    function void note_request(date_req_t r);
      pending_dates.push_back(advance_date(r));
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_date(date_res_t got);
      date_res_t want;
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %0d-%0d-%0d", $time,
                 got.year, got.month, got.day);
      end else begin
        want = pending_dates.pop_front();
        compare_field("end_day", want.day, got.day);
        compare_field("end_month", want.month, got.month);
        compare_field("end_year", want.year, got.year);
        compare_field("year_overflow", want.ovf, got.ovf);
        compare_field("invalid_date", want.bad, got.bad);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  opcode_i;
  logic [14:0] count_i;
  logic [4:0]  start_day_i;
  logic [3:0]  start_month_i;
  logic [15:0] start_year_i;
  logic        done_o;
  logic [4:0]  end_day_o;
  logic [3:0]  end_month_o;
  logic [15:0] end_year_o;
  logic        year_overflow_o;
  logic        invalid_date_o;

  date_scoreboard sb = new();

  calendar_date_advance uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .count_i        (count_i),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .done_o         (done_o),
    .end_day_o      (end_day_o),
    .end_month_o    (end_month_o),
    .end_year_o     (end_year_o),
    .year_overflow_o(year_overflow_o),
    .invalid_date_o (invalid_date_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic date_req_t mk_request(logic [2:0] op, int unsigned cnt, int unsigned d,
                                           int unsigned m, int unsigned y);
    date_req_t r;
    r.opcode = op;
    r.count  = 15'(cnt);
    r.day    = 5'(d);
    r.month  = 4'(m);
    r.year   = 16'(y);
    return r;
  endfunction

  function automatic date_req_t rand_request();
    date_req_t   r;
    int unsigned pick, len;
    r.opcode = 3'(($urandom_range(0, 99) < 92) ? $urandom_range(0, 4) : $urandom_range(5, 7));
    pick = $urandom_range(0, 99);
    if (pick < 80) r.count = 15'($urandom_range(0, 63));
    else if (pick < 95) r.count = 15'($urandom_range(0, 2047));
    else r.count = 15'($urandom_range(0, 32767));
    pick = $urandom_range(0, 99);
    if (pick < 35) r.year = 16'($urandom_range(1580, 2420));
    else if (pick < 55) r.year = 16'($urandom_range(65400, 65535));
    else if (pick < 70) r.year = 16'(100 * $urandom_range(0, 655));
    else r.year = 16'($urandom_range(0, 65535));
    r.month = 4'(($urandom_range(0, 99) < 95) ? $urandom_range(1, 12) : $urandom_range(0, 15));
    len = date_scoreboard::days_in(r.month, r.year);
    if (len != 0 && $urandom_range(0, 99) < 90) r.day = 5'($urandom_range(1, len));
    else r.day = 5'($urandom_range(0, 31));
    return r;
  endfunction

  // start stays high across back-to-back transfers; a nonzero gap lowers it and holds it
  // low until the block is free and the requested gap has run out
  task automatic drive_date_request(input date_req_t r, input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      while (busy) @(negedge clk_i);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    opcode_i      <= r.opcode;
    count_i       <= r.count;
    start_day_i   <= r.day;
    start_month_i <= r.month;
    start_year_i  <= r.year;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
  endtask

  always @(posedge clk_i) begin
    date_res_t got;
    if (rst_ni && done_o) begin
      got.day   = end_day_o;
      got.month = end_month_o;
      got.year  = end_year_o;
      got.ovf   = year_overflow_o;
      got.bad   = invalid_date_o;
      sb.check_date(got);
    end
  end

  initial begin
    date_req_t   directed[$];
    int unsigned i;
    int unsigned gap;
    rst_ni        = 1'b0;
    start         = 1'b0;
    opcode_i      = OP_ADD_DAYS;
    count_i       = '0;
    start_day_i   = 5'd1;
    start_month_i = 4'd1;
    start_year_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // leap rules, year wrap, max counts, month clamping, zero counts, invalid dates, unused opcodes
    directed.push_back(mk_request(OP_ADD_DAYS, 1, 28, 2, 2024));
    directed.push_back(mk_request(OP_ADD_DAYS, 1, 28, 2, 2023));
    directed.push_back(mk_request(OP_ADD_DAYS, 1, 28, 2, 1900));
    directed.push_back(mk_request(OP_ADD_DAYS, 1, 28, 2, 2000));
    directed.push_back(mk_request(OP_ADD_DAYS, 1, 31, 12, 65535));
    directed.push_back(mk_request(OP_ADD_DAYS, 32767, 31, 1, 0));
    directed.push_back(mk_request(OP_ADD_WEEKS, 32767, 1, 1, 2000));
    directed.push_back(mk_request(OP_ADD_MONTHS, 1, 31, 1, 2024));
    directed.push_back(mk_request(OP_ADD_MONTHS, 13, 31, 1, 2023));
    directed.push_back(mk_request(OP_ADD_MONTHS, 2, 30, 11, 65535));
    directed.push_back(mk_request(OP_ADD_MONTHS, 32767, 31, 12, 65000));
    directed.push_back(mk_request(OP_ADD_YEARS, 1, 29, 2, 2024));
    directed.push_back(mk_request(OP_ADD_YEARS, 1, 15, 6, 65535));
    directed.push_back(mk_request(OP_ADD_DECADES, 32767, 1, 1, 0));
    directed.push_back(mk_request(OP_ADD_DECADES, 100, 10, 10, 1999));
    directed.push_back(mk_request(OP_ADD_DAYS, 0, 31, 12, 65535));
    directed.push_back(mk_request(OP_ADD_MONTHS, 0, 31, 3, 2021));
    directed.push_back(mk_request(OP_ADD_DECADES, 0, 5, 5, 5));
    directed.push_back(mk_request(OP_ADD_DAYS, 5, 0, 3, 2020));
    directed.push_back(mk_request(OP_ADD_MONTHS, 5, 10, 0, 2020));
    directed.push_back(mk_request(OP_ADD_YEARS, 5, 10, 13, 2020));
    directed.push_back(mk_request(OP_ADD_WEEKS, 5, 31, 4, 2020));
    directed.push_back(mk_request(OP_ADD_DAYS, 5, 29, 2, 2023));
    directed.push_back(mk_request(3'd5, 100, 31, 15, 65535));
    directed.push_back(mk_request(3'd7, 32767, 15, 8, 2010));

    foreach (directed[k]) drive_date_request(directed[k], 0);

    for (i = 0; i < 560; i++) begin
      gap = 0;
      if ((i < 150 || i >= 330) && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 6);
      drive_date_request(rand_request(), gap);
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (sb.pending_dates.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
